@@ rtl/core/sab_pkg.sv @@
// Package: shared constants and types for the sample accumulation buffer.
package sab_pkg;
  localparam int unsigned DefImgWidth   = 1024;
  localparam int unsigned DefImgHeight  = 512;
  localparam int unsigned DefMaxSamples = 64;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned ColorW        = 8;
  localparam int unsigned XW            = 10;
  localparam int unsigned YW            = 9;
  localparam logic [31:0] GammaLhs      = 32'd655360000;
  localparam logic [31:0] GammaRhs      = 32'd655308801;
  localparam logic        OpAccum       = 1'b0;
  localparam logic        OpResolve     = 1'b1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_WRITE = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_SQRT  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;
endpackage

@@ rtl/core/sample_accumulation_buffer.sv @@
// Top level: per-pixel sample accumulator with gamma-2 resolve.
//
// Usage: drive in_* with start high while busy is low; that edge takes the
// transaction. op=0 adds an RGB sample to the pixel (no result). op=1
// resolves the pixel; the result appears on out_* for one cycle with
// out_valid high. The receiver cannot stall, so results are never held.
// The pixel memory is read into a register at the accepting edge.
// An accumulate holds busy through its read and write states (read, add and
// write back), so the next transaction can be taken once it is back in idle.
// A resolve runs a shared restoring divider, one quotient bit per cycle for
// each channel in turn (SW = 16 + CW sum bits), then an 8-step bitwise gamma
// search per channel and an output state: out_valid is high in the cycle
// after the output state, and the next transaction can be taken at the edge
// that ends that cycle. Out-of-image resolves return zeros; an accumulate
// writes nothing outside the image or once the pixel holds MAX_SAMPLES
// samples. After reset a clearing pass writes zero to every pixel entry,
// one per cycle; busy stays high meanwhile.
// Throughput is one transaction at a time.
module sample_accumulation_buffer
  import sab_pkg::*;
#(
  parameter int unsigned IMG_WIDTH   = DefImgWidth,
  parameter int unsigned IMG_HEIGHT  = DefImgHeight,
  parameter int unsigned MAX_SAMPLES = DefMaxSamples
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [sab_pkg::XW-1:0]        in_pix_x,
  input  logic [sab_pkg::YW-1:0]        in_pix_y,
  input  logic [sab_pkg::SampleW-1:0]   in_red_sample,
  input  logic [sab_pkg::SampleW-1:0]   in_green_sample,
  input  logic [sab_pkg::SampleW-1:0]   in_blue_sample,
  output logic                          out_valid,
  output logic [sab_pkg::YW-1:0]        out_display_row,
  output logic [sab_pkg::ColorW-1:0]    out_red_out,
  output logic [sab_pkg::ColorW-1:0]    out_green_out,
  output logic [sab_pkg::ColorW-1:0]    out_blue_out
);
  localparam int unsigned Depth = IMG_WIDTH * IMG_HEIGHT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW    = SampleW + CW;
  localparam int unsigned QW    = $clog2(SW);

  typedef struct packed {
    logic [SW-1:0] r;
    logic [SW-1:0] g;
    logic [SW-1:0] b;
    logic [CW-1:0] c;
  } entry_t;

  entry_t mem [Depth];
  entry_t rd_r;
  entry_t wr_data;
  logic   wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] rd_addr;

  state_t state_r;
  logic   op_r, inside_r;
  logic [SampleW-1:0] rs_r, gs_r, bs_r;
  logic [YW-1:0] row_r;
  logic [1:0] ch_r;
  logic [QW-1:0] bit_r;
  logic [SW-1:0] quo_r, rem_r;
  logic [SW-1:0] quo_nxt;
  logic [ColorW-1:0] k_r;
  logic [ColorW-1:0] res_r [3];
  logic [63:0] rhs_r;
  logic [SW-1:0] m_r [3];

  logic inside_in;
  logic [AW-1:0] addr_in;
  assign inside_in = (32'(in_pix_x) < IMG_WIDTH) && (32'(in_pix_y) < IMG_HEIGHT);
  assign addr_in = inside_in ? AW'(32'(in_pix_y) * IMG_WIDTH + 32'(in_pix_x)) : '0;

  // hold the read on the taken pixel while the transaction is in flight
  assign rd_addr = (state_r == ST_IDLE) ? addr_in : addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  assign busy = (state_r != ST_IDLE);

  logic [SW-1:0] cur_sum;
  always_comb begin
    case (ch_r)
      2'd0:    cur_sum = rd_r.r;
      2'd1:    cur_sum = rd_r.g;
      default: cur_sum = rd_r.b;
    endcase
  end

  logic [SW:0] trial;
  assign trial = {rem_r, cur_sum[SW-1-32'(bit_r)]} - {{(SW+1-CW){1'b0}}, rd_r.c};
  assign quo_nxt = {quo_r[SW-2:0], !trial[SW]};

  logic [ColorW-1:0] kt;
  logic [63:0] lhs;
  assign kt  = k_r | (ColorW'(1) << bit_r[2:0]);
  assign lhs = 64'(kt) * 64'(kt) * 64'(GammaLhs);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = rd_r;
    if (state_r == ST_CLEAR) begin
      wr_en = 1'b1;
      wr_data = '0;
    end else if (state_r == ST_WRITE) begin
      wr_en = inside_r && (32'(rd_r.c) < MAX_SAMPLES);
      wr_data.r = rd_r.r + SW'(rs_r);
      wr_data.g = rd_r.g + SW'(gs_r);
      wr_data.b = rd_r.b + SW'(bs_r);
      wr_data.c = rd_r.c + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      addr_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == ST_OUT);
      case (state_r)
        ST_CLEAR: begin
          addr_r <= addr_r + AW'(1);
          if (32'(addr_r) == Depth - 1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            addr_r <= addr_in; op_r <= in_op; inside_r <= inside_in;
            rs_r <= in_red_sample; gs_r <= in_green_sample; bs_r <= in_blue_sample;
            row_r <= YW'(IMG_HEIGHT - 1 - 32'(in_pix_y));
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          ch_r <= 2'd0; bit_r <= '0; rem_r <= '0;
          state_r <= (op_r == OpAccum) ? ST_WRITE : ST_DIV;
        end
        ST_WRITE: state_r <= ST_IDLE;
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle, reuse over channels
          if (32'(bit_r) == SW - 1) begin
            rem_r <= '0;
            m_r[ch_r] <= quo_nxt;
            if (ch_r == 2'd2) begin
              ch_r <= 2'd0; bit_r <= QW'(7); k_r <= '0;
              state_r <= ST_SQRT;
              rhs_r <= 64'(m_r[0]) * 64'(GammaRhs);
            end else begin
              ch_r <= ch_r + 2'd1;
              bit_r <= '0;
            end
          end else begin
            rem_r <= trial[SW] ? {rem_r[SW-2:0], cur_sum[SW-1-32'(bit_r)]} : trial[SW-1:0];
            quo_r <= quo_nxt;
            bit_r <= bit_r + QW'(1);
          end
        end
        ST_SQRT: begin
          if (bit_r == '0) begin
            res_r[ch_r] <= (lhs <= rhs_r) ? kt : k_r;
            k_r <= '0; bit_r <= QW'(7);
            if (ch_r == 2'd2) state_r <= ST_OUT;
            else begin
              ch_r <= ch_r + 2'd1;
              rhs_r <= 64'(m_r[ch_r + 2'd1]) * 64'(GammaRhs);
            end
          end else begin
            if (lhs <= rhs_r) k_r <= kt;
            bit_r <= bit_r - QW'(1);
          end
        end
        ST_OUT: begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  logic zero_c;
  assign zero_c = !inside_r || (rd_r.c == '0);
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      out_display_row <= inside_r ? row_r : '0;
      out_red_out     <= zero_c ? '0 : res_r[0];
      out_green_out   <= zero_c ? '0 : res_r[1];
      out_blue_out    <= zero_c ? '0 : res_r[2];
    end
  end

  a_out_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_OUT) else $error("result without resolve");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !wr_en) else $error("write while idle");
  a_busy_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> busy) else $error("transaction not taken");
endmodule

@@ bench/tb_sample_accumulation_buffer.sv @@
// Testbench for the sample accumulation buffer: directed table plus random traffic, predictor-checked.
`timescale 1ns / 1ps
module tb_sample_accumulation_buffer;
  import sab_pkg::*;

  localparam int unsigned HEIGHT = DefImgHeight;
  localparam int unsigned MAXS   = DefMaxSamples;
  localparam int unsigned RAND_ITEMS = 1900;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [YW-1:0]     row;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } pixel_out_t;

  typedef struct {
    logic              op;
    logic [XW-1:0]     x;
    logic [YW-1:0]     y;
    logic [SampleW-1:0] r, g, b;
    int                reps;
    bit                known;
    pixel_out_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = OpAccum;
  logic [XW-1:0] in_pix_x = '0;
  logic [YW-1:0] in_pix_y = '0;
  logic [SampleW-1:0] in_red_sample = '0, in_green_sample = '0, in_blue_sample = '0;
  logic out_valid;
  logic [YW-1:0] out_display_row;
  logic [ColorW-1:0] out_red_out, out_green_out, out_blue_out;

  sample_accumulation_buffer uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sparse shadow of the pixel store; missing entries read as zero
  int unsigned red_acc[int], green_acc[int], blue_acc[int], hits[int];
  pixel_out_t pending_px[$];
  int errors = 0;
  int resolves = 0, accums = 0, full_drops = 0;
  longint unsigned cycles = 0;

  function automatic logic [ColorW-1:0] gamma_of(int unsigned sum, int unsigned cnt);
    longint unsigned mean, rhs, k, t;
    k = 0;
    if (cnt == 0) return '0;
    mean = 64'(sum / cnt);
    rhs = mean * longint'(GammaRhs);
    for (int bitn = 7; bitn >= 0; bitn--) begin
      t = k | (64'd1 << bitn);
      if (t * t * longint'(GammaLhs) <= rhs) k = t;
    end
    return k[ColorW-1:0];
  endfunction

  // update the shadow store; returns 1 with the expected pixel on a resolve
  function automatic bit apply_item(logic op, logic [XW-1:0] x, logic [YW-1:0] y,
      logic [SampleW-1:0] r, logic [SampleW-1:0] g, logic [SampleW-1:0] b,
      output pixel_out_t px);
    int idx;
    int unsigned c;
    idx = int'(y) * DefImgWidth + int'(x);
    c = hits.exists(idx) ? hits[idx] : 0;
    px = '0;
    if (op == OpAccum) begin
      if (c < MAXS) begin
        red_acc[idx]   = (red_acc.exists(idx) ? red_acc[idx] : 0) + 32'(r);
        green_acc[idx] = (green_acc.exists(idx) ? green_acc[idx] : 0) + 32'(g);
        blue_acc[idx]  = (blue_acc.exists(idx) ? blue_acc[idx] : 0) + 32'(b);
        hits[idx] = c + 1;
      end else begin
        full_drops++;
      end
      return 1'b0;
    end
    px.row   = YW'(HEIGHT - 1 - 32'(y));
    px.red   = gamma_of(red_acc.exists(idx) ? red_acc[idx] : 0, c);
    px.green = gamma_of(green_acc.exists(idx) ? green_acc[idx] : 0, c);
    px.blue  = gamma_of(blue_acc.exists(idx) ? blue_acc[idx] : 0, c);
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_out_t w;
    if (rst_n && out_valid) begin
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected result row", longint'(out_display_row), -1);
      end else begin
        w = pending_px.pop_front();
        if (out_display_row !== w.row)
          report_mismatch("display_row", longint'(out_display_row), longint'(w.row));
        if (out_red_out !== w.red)
          report_mismatch("red_out", longint'(out_red_out), longint'(w.red));
        if (out_green_out !== w.green)
          report_mismatch("green_out", longint'(out_green_out), longint'(w.green));
        if (out_blue_out !== w.blue)
          report_mismatch("blue_out", longint'(out_blue_out), longint'(w.blue));
      end
    end
  end

  // present one transaction, hold until taken, then optionally idle
  task automatic issue(logic op, logic [XW-1:0] x, logic [YW-1:0] y,
      logic [SampleW-1:0] r, logic [SampleW-1:0] g, logic [SampleW-1:0] b, int gap);
    pixel_out_t px;
    @(negedge clk);
    start <= 1'b1;
    in_op <= op;
    in_pix_x <= x;
    in_pix_y <= y;
    in_red_sample <= r;
    in_green_sample <= g;
    in_blue_sample <= b;
    do @(posedge clk); while (busy);
    if (apply_item(op, x, y, r, g, b, px)) begin
      pending_px.push_back(px);
      resolves++;
    end else begin
      accums++;
    end
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  stim_row_t plan[$];

  function automatic stim_row_t mk(logic op, int x, int y, int r, int g, int b,
      int reps, bit known, pixel_out_t want);
    stim_row_t s;
    s.op = op; s.x = XW'(x); s.y = YW'(y);
    s.r = SampleW'(r); s.g = SampleW'(g); s.b = SampleW'(b);
    s.reps = reps; s.known = known; s.want = want;
    return s;
  endfunction

  initial begin
    logic [XW-1:0] hx[16];
    logic [YW-1:0] hy[16];
    int sel;
    bit burst;

    // empty pixels at the corners
    plan.push_back(mk(OpResolve, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, '{9'd511, 0, 0, 0}));
    plan.push_back(mk(OpResolve, 1023, 511, 0, 0, 0, 1, 1, '{9'd0, 0, 0, 0}));
    // fill one pixel with full-scale samples past its capacity
    plan.push_back(mk(OpAccum, 1023, 511, 16'hFFFF, 16'hFFFF, 16'hFFFF, MAXS + 3, 0, '0));
    plan.push_back(mk(OpResolve, 1023, 511, 0, 0, 0, 1, 1, '{9'd0, 8'd255, 8'd255, 8'd255}));
    // zero samples still count
    plan.push_back(mk(OpAccum, 0, 0, 0, 0, 0, 4, 0, '0));
    plan.push_back(mk(OpResolve, 0, 0, 0, 0, 0, 1, 1, '{9'd511, 0, 0, 0}));
    // mixed channels, single and several samples
    plan.push_back(mk(OpAccum, 512, 256, 16'h0001, 16'h8000, 16'hFFFF, 1, 0, '0));
    plan.push_back(mk(OpResolve, 512, 256, 0, 0, 0, 1, 0, '0));
    plan.push_back(mk(OpAccum, 512, 256, 16'h4000, 16'h0100, 16'h0000, 2, 0, '0));
    plan.push_back(mk(OpResolve, 512, 256, 16'h1234, 16'h5678, 16'h9ABC, 1, 0, '0));
    plan.push_back(mk(OpAccum, 341, 170, 16'h5555, 16'hAAAA, 16'h00FF, 1, 0, '0));
    plan.push_back(mk(OpResolve, 341, 170, 0, 0, 0, 1, 0, '0));
    plan.push_back(mk(OpAccum, 682, 341, 16'hAAAA, 16'h5555, 16'hFF00, 7, 0, '0));
    plan.push_back(mk(OpResolve, 682, 341, 0, 0, 0, 1, 0, '0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      for (int n = 0; n < plan[i].reps; n++) begin
        issue(plan[i].op, plan[i].x, plan[i].y, plan[i].r, plan[i].g, plan[i].b, pick_gap());
        if (plan[i].known && pending_px.size() > 0 && pending_px[$] !== plan[i].want) begin
          report_mismatch("directed expectation", longint'(pending_px[$]),
                          longint'(plan[i].want));
          pending_px[$] = plan[i].want;
        end
      end
    end

    // hot pixels so counts reach capacity and resolves see real averages
    foreach (hx[i]) begin
      hx[i] = XW'($urandom_range(1023));
      hy[i] = YW'($urandom_range(511));
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      logic op;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      burst = (n % 400) < 40;
      op = ($urandom_range(99) < 30) ? OpResolve : OpAccum;
      if ($urandom_range(99) < 80) begin
        sel = $urandom_range(15);
        x = hx[sel];
        y = hy[sel];
      end else begin
        x = XW'($urandom_range(1023));
        y = YW'($urandom_range(511));
      end
      issue(op, x, y, SampleW'($urandom_range(65535)), SampleW'($urandom_range(65535)),
            SampleW'($urandom_range(65535)), burst ? 0 : pick_gap());
      if (n == RAND_ITEMS / 2) begin
        // drain all outstanding resolves before carrying on
        @(negedge clk);
        start <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d accumulates (%0d dropped at capacity) and %0d resolves",
             accums, full_drops, resolves);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/sab_pkg.sv
rtl/core/sample_accumulation_buffer.sv
bench/tb_sample_accumulation_buffer.sv
